FILE: rtl/zcdp_pkg.sv
// Package for the ZIP central directory parser.
// Holds result kind codes, the result item layout, the header signature and the shared queue depth.
// No dependencies.
package zcdp_pkg;

   localparam int unsigned RQ_DEPTH = 4;

   localparam logic [31:0] CDH_SIGNATURE = 32'h0201_4b50;

   typedef enum logic [2:0] {
      K_RECORD = 3'd0,
      K_NAME   = 3'd1,
      K_DONE   = 3'd2,
      K_BADSIG = 3'd3,
      K_TRUNC  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] entry_index;
      logic [15:0] method;
      logic [31:0] packed_size;
      logic [31:0] plain_size;
      logic [31:0] header_offset;
      logic [15:0] name_length;
      logic [7:0]  name_char;
      logic        final_res;
   } rsp_type;

   // Up to two result items come out of one input item, in slot order.
   typedef struct packed {
      logic    v0;
      logic    v1;
      rsp_type r0;
      rsp_type r1;
   } push_type;

endpackage

FILE: rtl/zcdp_core.sv
// Parser core: header field capture, name/skip counting and result generation.
// Works on one accepted item per cycle; depends on zcdp_pkg.
module zcdp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   input  logic              item_accept,
   input  logic [7:0]        data_byte,
   input  logic              stream_end,
   output zcdp_pkg::push_type push
);
   import zcdp_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_NAME,
      PH_SKIP,
      PH_STOP
   } phase_type;

   typedef struct packed {
      logic [31:0] sig;
      logic [15:0] method;
      logic [15:0] name_len;
      logic [31:0] packed_size;
      logic [31:0] plain_size;
      logic [15:0] extra_len;
      logic [15:0] comment_len;
      logic [31:0] offset;
   } hdr_type;

   localparam logic [5:0] HDR_LAST  = 6'd45;
   localparam logic [5:0] OFS_FIRST = 6'd42;

   phase_type   phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   hdr_type     hdr_ff, hdr_in;
   logic [16:0] left_ff, left_in;
   logic [15:0] done_ff, done_in;
   logic [15:0] total_ff, total_in;

   logic [16:0] skip_len;
   logic [16:0] left_dec;
   logic [1:0]  ofs_sub;
   logic        finished;
   logic        stopped;
   push_type    push_c;

   function automatic rsp_type make_rsp(kind_type k, logic [15:0] idx, hdr_type h,
                                        logic with_entry, logic [7:0] ch, logic fin);
      rsp_type r;
      r.kind          = k;
      r.entry_index   = idx;
      r.method        = with_entry ? h.method      : 16'd0;
      r.packed_size   = with_entry ? h.packed_size : 32'd0;
      r.plain_size    = with_entry ? h.plain_size  : 32'd0;
      r.header_offset = with_entry ? h.offset      : 32'd0;
      r.name_length   = with_entry ? h.name_len    : 16'd0;
      r.name_char     = ch;
      r.final_res     = fin;
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      hdr_in   = hdr_ff;
      left_in  = left_ff;
      done_in  = done_ff;
      total_in = csr_we ? csr_wdata : total_ff;
      finished = 1'b0;
      stopped  = 1'b0;
      push_c   = '0;
      ofs_sub  = 2'(pos_ff - OFS_FIRST);
      left_dec = (left_ff != 17'd0) ? left_ff - 17'd1 : 17'd0;

      // header capture, in place for the record of the final header byte
      case (pos_ff) inside
         [6'd0:6'd3]:   hdr_in.sig[pos_ff[1:0]*8 +: 8]         = data_byte;
         [6'd10:6'd11]: hdr_in.method[pos_ff[0]*8 +: 8]        = data_byte;
         [6'd20:6'd23]: hdr_in.packed_size[pos_ff[1:0]*8 +: 8] = data_byte;
         [6'd24:6'd27]: hdr_in.plain_size[pos_ff[1:0]*8 +: 8]  = data_byte;
         [6'd28:6'd29]: hdr_in.name_len[pos_ff[0]*8 +: 8]      = data_byte;
         [6'd30:6'd31]: hdr_in.extra_len[pos_ff[0]*8 +: 8]     = data_byte;
         [6'd32:6'd33]: hdr_in.comment_len[pos_ff[0]*8 +: 8]   = data_byte;
         [6'd42:6'd45]: hdr_in.offset[ofs_sub*8 +: 8]          = data_byte;
         default: ;
      endcase
      if (phase_ff != PH_HEADER)
         hdr_in = hdr_ff;

      skip_len = {1'b0, hdr_in.extra_len} + {1'b0, hdr_in.comment_len};

      if (!item_accept || phase_ff == PH_STOP) begin
         hdr_in = hdr_ff;
      end else if (phase_ff == PH_HEADER && pos_ff == 6'd0 && done_ff >= total_ff) begin
         push_c.v0 = 1'b1;
         push_c.r0 = make_rsp(K_DONE, done_ff, hdr_ff, 1'b0, 8'd0, 1'b1);
         phase_in  = PH_STOP;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               if (pos_ff >= HDR_LAST) begin
                  pos_in = 6'd0;
                  push_c.v0 = 1'b1;
                  if (hdr_in.sig != CDH_SIGNATURE) begin
                     push_c.r0 = make_rsp(K_BADSIG, done_ff, hdr_in, 1'b0, 8'd0, 1'b1);
                     phase_in  = PH_STOP;
                     stopped   = 1'b1;
                  end else begin
                     push_c.r0 = make_rsp(K_RECORD, done_ff, hdr_in, 1'b1, 8'd0, 1'b0);
                     if (hdr_in.name_len != 16'd0) begin
                        phase_in = PH_NAME;
                        left_in  = {1'b0, hdr_in.name_len};
                     end else if (skip_len != 17'd0) begin
                        phase_in = PH_SKIP;
                        left_in  = skip_len;
                     end else begin
                        finished = 1'b1;
                     end
                  end
               end else begin
                  pos_in = pos_ff + 6'd1;
               end
            end
            PH_NAME: begin
               push_c.v0 = 1'b1;
               push_c.r0 = make_rsp(K_NAME, done_ff, hdr_ff, 1'b1, data_byte, 1'b0);
               left_in   = left_dec;
               if (left_dec == 17'd0) begin
                  if (skip_len != 17'd0) begin
                     phase_in = PH_SKIP;
                     left_in  = skip_len;
                  end else begin
                     finished = 1'b1;
                  end
               end
            end
            default: begin
               left_in = left_dec;
               if (left_dec == 17'd0)
                  finished = 1'b1;
            end
         endcase

         if (finished) begin
            done_in  = done_ff + 16'd1;
            phase_in = PH_HEADER;
            pos_in   = 6'd0;
            if (done_in >= total_ff) begin
               stopped  = 1'b1;
               phase_in = PH_STOP;
               if (push_c.v0) begin
                  push_c.v1 = 1'b1;
                  push_c.r1 = make_rsp(K_DONE, done_in, hdr_ff, 1'b0, 8'd0, 1'b1);
               end else begin
                  push_c.v0 = 1'b1;
                  push_c.r0 = make_rsp(K_DONE, done_in, hdr_ff, 1'b0, 8'd0, 1'b1);
               end
            end
         end

         if (!stopped && stream_end) begin
            phase_in = PH_STOP;
            if (push_c.v0) begin
               push_c.v1 = 1'b1;
               push_c.r1 = make_rsp(K_TRUNC, done_in, hdr_ff, 1'b0, 8'd0, 1'b1);
            end else begin
               push_c.v0 = 1'b1;
               push_c.r0 = make_rsp(K_TRUNC, done_in, hdr_ff, 1'b0, 8'd0, 1'b1);
            end
         end
      end
   end

   assign push = push_c;

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= 6'd0;
         left_ff  <= 17'd0;
         done_ff  <= 16'd0;
         total_ff <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         left_ff  <= left_in;
         done_ff  <= done_in;
         total_ff <= total_in;
      end
   end

   a_stop_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STOP |-> !push.v0)
      else $error("result produced after stop");

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> push.v0 && push.r1.final_res)
      else $error("second result slot misused");

   a_final_stops: assert property (@(posedge clock) disable iff (reset)
      push.v0 && push.r0.final_res |=> phase_ff == PH_STOP)
      else $error("terminal result without stop");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= HDR_LAST)
      else $error("header position out of range");

endmodule

FILE: rtl/zcdp_fifo.sv
// Result queue between the parser core and the result channel.
// Takes up to two items per cycle, hands out one; depends on zcdp_pkg.
module zcdp_fifo #(
   parameter int unsigned DEPTH = zcdp_pkg::RQ_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  zcdp_pkg::push_type push,
   input  logic               pop,
   output logic               room2,
   output logic               not_empty,
   output zcdp_pkg::rsp_type  head
);
   import zcdp_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_ROOM = CW'(DEPTH - 2);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   rsp_type         mem [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CW-1:0]   cnt_ff, cnt_in;

   function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_next = ptr_inc(wr_ff);
      wr_in   = wr_ff;
      if (push.v1)
         wr_in = ptr_inc(wr_next);
      else if (push.v0)
         wr_in = wr_next;
      rd_in  = pop ? ptr_inc(rd_ff) : rd_ff;
      cnt_in = cnt_ff + CW'(push.v0) + CW'(push.v1) - CW'(pop);
   end

   assign room2     = (cnt_ff <= CNT_ROOM);
   assign not_empty = (cnt_ff != '0);
   assign head      = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push.v0)
         mem[wr_ff] <= push.r0;
      if (push.v1)
         mem[wr_next] <= push.r1;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("result queue underflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.v0 |-> cnt_ff <= CNT_ROOM)
      else $error("push without room");

endmodule

FILE: rtl/zip_central_directory_parser.sv
// ZIP central directory parser, top level.
// Instantiates zcdp_core and zcdp_fifo; depends on zcdp_pkg.
//
// Usage: the central directory streams in one byte per item on req_ (tlast
// marks the final byte available). csr_wdata, written with csr_we while the
// block is idle, sets the number of entries expected. For each entry the
// rsp_ channel gives one record item, then one item per file name byte;
// extra-field and comment bytes give nothing. Done, bad signature and
// truncation items carry rsp_tlast and stop the block until reset.
// Throughput: one input item per cycle while req_tready is high; a byte is parsed
// in the cycle it is accepted and its results sit in the result queue from the
// next cycle, at the head if the queue was empty. One byte can cause two
// results while the queue drains one per cycle, so req_tready drops when the
// queue has fewer than two free slots (DEPTH entries).
// Reset (synchronous) clears the parser, the entry count and the queue.
// A stalled receiver only fills the queue; nothing is lost.
module zip_central_directory_parser #(
   parameter int unsigned DEPTH = zcdp_pkg::RQ_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // stream_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // entry_index, method, packed_size, plain_size,
                                     // header_offset, name_length, name_char
   output logic [2:0]   rsp_tuser,   // kind
   output logic         rsp_tlast    // final_res
);
   import zcdp_pkg::*;

   push_type push;
   rsp_type  head;
   logic     room2;
   logic     not_empty;
   logic     item_accept;
   logic     pop;

   assign req_tready  = room2;
   assign item_accept = req_tvalid && room2;
   assign rsp_tvalid  = not_empty;
   assign pop         = not_empty && rsp_tready;

   zcdp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .item_accept (item_accept),
      .data_byte   (req_tdata),
      .stream_end  (req_tlast),
      .push        (push)
   );

   zcdp_fifo #(
      .DEPTH (DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .room2     (room2),
      .not_empty (not_empty),
      .head      (head)
   );

   assign rsp_tdata = {head.name_char, head.name_length, head.header_offset,
                       head.plain_size, head.packed_size, head.method,
                       head.entry_index};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.final_res;

endmodule
